// File: sv/char_lcd_nibble_write_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character display bus sequencer
// Shared property templates for the concurrent checks of the top level.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define LCDSEQ_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcdseq: same-cycle check failed");

// next-cycle implication under synchronous active-low reset
`define LCDSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcdseq: next-cycle check failed");

`endif

// File: sv/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, constants and the init command table of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

    localparam int COLUMNS    = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;
    localparam int INIT_BYTES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWERUP = 2'd2;

    localparam logic [15:0] PULSE_RST   = 16'd20;
    localparam logic [15:0] SETTLE_RST  = 16'd2000;
    localparam logic [15:0] POWERUP_RST = 16'd20000;

    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] LINE1      = 8'd1;
    localparam logic [7:0] LINE2      = 8'd2;
    localparam logic [7:0] SLOT_LIMIT = 8'd8;

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_CMD      = 3'd1,
        OP_CHAR     = 3'd2,
        OP_CURSOR   = 3'd3,
        OP_CHAR_POS = 3'd4,
        OP_SLOT     = 3'd5
    } opcode_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       wait_phase;
        logic [2:0] byte_idx;
        logic       nib_lo;
        logic       en_level;
        logic       last;
    } lcdseq_cmd_t;

    typedef struct packed {
        logic [2:0] n_bytes;
        logic       is_init;
        logic       out_free;
    } lcdseq_status_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0C;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/lcdseq_ctrl.sv
// ----------------------------------------------------------------------------
// lcdseq_ctrl
// Phase sequencer: walks the bytes and nibble phases of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_ctrl
    import lcdseq_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire lcdseq_status_t status,
    output lcdseq_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] nbytes_reg, nbytes_next;
    logic [2:0] bidx_reg, bidx_next;
    logic [1:0] sub_reg, sub_next;
    logic       last_ph;

    assign s_tready = (state_reg == ST_IDLE);
    assign last_ph  = (bidx_reg == (nbytes_reg - 3'd1)) && (sub_reg == 2'd3);

    always_comb begin
        state_next     = state_reg;
        nbytes_next    = nbytes_reg;
        bidx_next      = bidx_reg;
        sub_next       = sub_reg;
        cmd            = '0;
        cmd.byte_idx   = bidx_reg;
        cmd.nib_lo     = sub_reg[1];
        cmd.en_level   = ~sub_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    nbytes_next = status.n_bytes;
                    bidx_next   = 3'd0;
                    sub_next    = 2'd0;
                    if (status.is_init) begin
                        state_next = ST_WAIT;
                    end else if (status.n_bytes != 3'd0) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_WAIT: begin
                cmd.wait_phase = 1'b1;
                cmd.en_level   = 1'b0;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.last = last_ph;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd3) begin
                        bidx_next = bidx_reg + 3'd1;
                    end
                    if (last_ph) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            nbytes_reg <= 3'd0;
            bidx_reg   <= 3'd0;
            sub_reg    <= 2'd0;
        end else begin
            state_reg  <= state_next;
            nbytes_reg <= nbytes_next;
            bidx_reg   <= bidx_next;
            sub_reg    <= sub_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/lcdseq_dp.sv
// ----------------------------------------------------------------------------
// lcdseq_dp
// Datapath: item decode, byte selection, timing registers, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire lcdseq_cmd_t          cmd,
    output lcdseq_status_t            status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tlast
);

    logic [2:0] in_op;
    logic [7:0] in_val, in_line, in_col, in_slot;
    logic       line_ok;
    logic [7:0] line_base;
    logic [7:0] first_byte;
    logic       first_rs;
    logic [2:0] n_bytes;

    logic [15:0] pulse_reg, settle_reg, powerup_reg;
    logic        init_reg;
    logic [7:0]  b0_reg, val_reg;
    logic        rs0_reg;

    logic        out_valid_reg;
    logic [3:0]  nib_reg;
    logic        rs_reg, en_reg, last_reg;
    logic [15:0] hold_reg;

    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic [3:0]  cur_nib;

    assign in_op   = s_tdata[2:0];
    assign in_val  = s_tdata[10:3];
    assign in_line = s_tdata[18:11];
    assign in_col  = s_tdata[26:19];
    assign in_slot = s_tdata[34:27];

    always_comb begin
        line_ok   = (in_line == LINE1) || (in_line == LINE2);
        line_base = (in_line == LINE1) ? LINE1_BASE : LINE2_BASE;
        first_byte = line_base | {4'h0, in_col[3:0]};
        first_rs   = 1'b0;
        n_bytes    = 3'd0;
        unique case (in_op)
            OP_INIT: n_bytes = 3'(INIT_BYTES);
            OP_CMD: begin
                first_byte = in_val;
                n_bytes    = 3'd1;
            end
            OP_CHAR: begin
                first_byte = in_val;
                first_rs   = 1'b1;
                n_bytes    = 3'd1;
            end
            OP_CURSOR: n_bytes = line_ok ? 3'd1 : 3'd0;
            OP_CHAR_POS: n_bytes = (line_ok && (in_col < 8'(COLUMNS))) ? 3'd2 : 3'd0;
            OP_SLOT: begin
                first_byte = {2'b01, in_slot[2:0], 3'b000};
                n_bytes    = (in_slot < SLOT_LIMIT) ? 3'd1 : 3'd0;
            end
            default: n_bytes = 3'd0;
        endcase
    end

    assign status.n_bytes  = n_bytes;
    assign status.is_init  = (in_op == OP_INIT);
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg   <= PULSE_RST;
            settle_reg  <= SETTLE_RST;
            powerup_reg <= POWERUP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PULSE:   pulse_reg   <= cfg_wdata;
                CFG_SETTLE:  settle_reg  <= cfg_wdata;
                CFG_POWERUP: powerup_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            init_reg <= (in_op == OP_INIT);
            b0_reg   <= first_byte;
            rs0_reg  <= first_rs;
            val_reg  <= in_val;
        end
    end

    always_comb begin
        if (init_reg) begin
            cur_byte = init_byte(cmd.byte_idx);
            cur_rs   = 1'b0;
        end else if (cmd.byte_idx == 3'd0) begin
            cur_byte = b0_reg;
            cur_rs   = rs0_reg;
        end else begin
            cur_byte = val_reg;
            cur_rs   = 1'b1;
        end
        cur_nib = cmd.nib_lo ? cur_byte[3:0] : cur_byte[7:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (cmd.wait_phase) begin
                nib_reg  <= 4'h0;
                rs_reg   <= 1'b0;
                en_reg   <= 1'b0;
                hold_reg <= powerup_reg;
                last_reg <= 1'b0;
            end else begin
                nib_reg  <= cur_nib;
                rs_reg   <= cur_rs;
                en_reg   <= cmd.en_level;
                hold_reg <= cmd.en_level ? pulse_reg : settle_reg;
                last_reg <= cmd.last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, hold_reg, en_reg, rs_reg, nib_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// File: sv/char_lcd_nibble_write_sequencer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top
// Flow: a request is taken in idle; the wait state (init only) and the run
// state then emit its phases in order into the output register; m_tready low
// holds them. Rejected requests emit none; idle returns after the last phase.
// Reset: synchronous active-low aresetn; timing back to 20/2000/20000 us, idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "char_lcd_nibble_write_sequencer_top_defines.svh"

module char_lcd_nibble_write_sequencer_top
    import lcdseq_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // opcode[2:0], byte_value[10:3], line_number[18:11], column[26:19],
    // glyph_slot[34:27], zero fill
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // data_nibble[3:0], reg_select[4], enable_level[5], hold_us[21:6], zero fill
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tlast,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    lcdseq_cmd_t    cmd;
    lcdseq_status_t status;

    lcdseq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcdseq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `LCDSEQ_ASSERT_IMPLY(a_no_emit_when_idle, aclk, aresetn, s_tready, !cmd.emit)
    `LCDSEQ_ASSERT_NEXT(a_empty_item_stays_idle, aclk, aresetn,
        s_tvalid && s_tready && !status.is_init && (status.n_bytes == 3'd0), s_tready)
    `LCDSEQ_ASSERT_IMPLY(a_last_phase_enable_low, aclk, aresetn,
        cmd.emit && cmd.last, !cmd.en_level && !cmd.wait_phase)

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the four-bit character display bus sequencer. Display
// requests go in on the s_ stream and each expands to a run of bus phases.
// An in-bench predictor of that expansion queues the expected phases as each
// request is taken. Every phase taken from the m_ stream is then compared
// field by field against the oldest entry. The stimulus covers directed
// corner requests, timing extremes and rounds of random traffic. Each random
// round uses new timing values. Both sides stall at random but in one round.
// ----------------------------------------------------------------------------
module tb;
    import lcdseq_pkg::*;

    localparam int          LATENCY_WAIT = 4;
    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          ROUNDS       = 6;
    localparam int          ROUND_ITEMS  = 48;
    localparam logic [2:0]  OP_SPARE6    = 3'd6;
    localparam logic [2:0]  OP_SPARE7    = 3'd7;
    localparam logic [7:0]  SLOT_BASE    = 8'h40;
    localparam logic [47:0] INIT_CMDS    = 48'h33_32_28_06_0C_01;

    typedef struct packed {
        logic [7:0] slot;
        logic [7:0] col;
        logic [7:0] line;
        logic [7:0] value;
        logic [2:0] op;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic        en;
        logic [15:0] hold;
        logic        last;
    } bus_phase_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic [15:0] pulse_q   = PULSE_RST;
    logic [15:0] settle_q  = SETTLE_RST;
    logic [15:0] powerup_q = POWERUP_RST;
    bus_phase_t  pending_phases[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          gaps_on     = 1'b1;

    char_lcd_nibble_write_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_phase(input logic [3:0] nib, input logic rs,
                                       input logic en, input logic [15:0] hold,
                                       input logic last);
        bus_phase_t p;
        p.nibble = nib;
        p.rs     = rs;
        p.en     = en;
        p.hold   = hold;
        p.last   = last;
        pending_phases.push_back(p);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic rs,
                                      input logic last);
        push_phase(b[7:4], rs, 1'b1, pulse_q, 1'b0);
        push_phase(b[7:4], rs, 1'b0, settle_q, 1'b0);
        push_phase(b[3:0], rs, 1'b1, pulse_q, 1'b0);
        push_phase(b[3:0], rs, 1'b0, settle_q, last);
    endfunction

    function automatic void expand_request(input logic [S_DATA_W-1:0] d);
        lcd_req_t   r;
        logic       line_ok;
        logic [7:0] addr;
        int         i;
        r       = lcd_req_t'(d[$bits(lcd_req_t)-1:0]);
        line_ok = (r.line == LINE1) || (r.line == LINE2);
        addr    = ((r.line == LINE2) ? LINE2_BASE : LINE1_BASE) | {4'h0, r.col[3:0]};
        case (r.op)
            OP_INIT: begin
                push_phase(4'h0, 1'b0, 1'b0, powerup_q, 1'b0);
                for (i = 0; i < INIT_BYTES; i++)
                    push_byte(INIT_CMDS[47 - 8 * i -: 8], 1'b0, i == INIT_BYTES - 1);
            end
            OP_CMD:    push_byte(r.value, 1'b0, 1'b1);
            OP_CHAR:   push_byte(r.value, 1'b1, 1'b1);
            OP_CURSOR: begin
                if (line_ok)
                    push_byte(addr, 1'b0, 1'b1);
            end
            OP_CHAR_POS: begin
                if (line_ok && r.col < COLUMNS) begin
                    push_byte(addr, 1'b0, 1'b0);
                    push_byte(r.value, 1'b1, 1'b1);
                end
            end
            OP_SLOT: begin
                if (r.slot < SLOT_LIMIT)
                    push_byte(SLOT_BASE + {r.slot[4:0], 3'b000}, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_phase();
        bus_phase_t e;
        if (pending_phases.size() == 0) begin
            $error("unexpected phase: tdata %h tlast %b", m_tdata, m_tlast);
            fail_count++;
            return;
        end
        e = pending_phases.pop_front();
        if (m_tdata[3:0] !== e.nibble) begin
            $error("data_nibble: expected %0h, got %0h", e.nibble, m_tdata[3:0]);
            fail_count++;
        end
        if (m_tdata[4] !== e.rs) begin
            $error("reg_select: expected %0d, got %0d", e.rs, m_tdata[4]);
            fail_count++;
        end
        if (m_tdata[5] !== e.en) begin
            $error("enable_level: expected %0d, got %0d", e.en, m_tdata[5]);
            fail_count++;
        end
        if (m_tdata[21:6] !== e.hold) begin
            $error("hold_us: expected %0d, got %0d", e.hold, m_tdata[21:6]);
            fail_count++;
        end
        if (m_tlast !== e.last) begin
            $error("last_phase: expected %0d, got %0d", e.last, m_tlast);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expand_request(s_tdata);
            if (m_tvalid && m_tready)
                check_phase();
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("char_lcd_nibble_write_sequencer_top: mismatch");
            $finish;
        end
    end

    function automatic lcd_req_t make_req(input logic [2:0] op, input logic [7:0] value,
                                          input logic [7:0] line, input logic [7:0] col,
                                          input logic [7:0] slot);
        lcd_req_t r;
        r.op    = op;
        r.value = value;
        r.line  = line;
        r.col   = col;
        r.slot  = slot;
        return r;
    endfunction

    function automatic lcd_req_t random_request();
        lcd_req_t r;
        int       pick;
        pick    = $urandom_range(0, 99);
        r.value = 8'($urandom_range(0, 255));
        r.line  = ($urandom_range(0, 99) < 85) ? (($urandom_range(0, 1) == 0) ? LINE1 : LINE2)
                                               : 8'($urandom_range(0, 255));
        r.col   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, COLUMNS - 1))
                                               : 8'($urandom_range(0, 255));
        r.slot  = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, SLOT_LIMIT - 1))
                                               : 8'($urandom_range(0, 255));
        if (pick < 4)       r.op = OP_INIT;
        else if (pick < 22) r.op = OP_CMD;
        else if (pick < 42) r.op = OP_CHAR;
        else if (pick < 58) r.op = OP_CURSOR;
        else if (pick < 80) r.op = OP_CHAR_POS;
        else if (pick < 94) r.op = OP_SLOT;
        else                r.op = ($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7;
        return r;
    endfunction

    function automatic logic [15:0] random_timing();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return 16'h0000;
        if (pick < 30) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_request(input lcd_req_t r);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - $bits(lcd_req_t)){1'b0}}, r};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_phases.size() != 0) @(negedge aclk);
        repeat (LATENCY_WAIT) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PULSE:   pulse_q   = v;
            CFG_SETTLE:  settle_q  = v;
            CFG_POWERUP: powerup_q = v;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] pulse, input logic [15:0] settle,
                              input logic [15:0] powerup);
        write_register(CFG_PULSE, pulse);
        write_register(CFG_SETTLE, settle);
        write_register(CFG_POWERUP, powerup);
    endtask

    task automatic test_reset_defaults();
        send_request(make_req(OP_INIT,     8'h00, 8'd0,   8'd0,   8'd0));
        send_request(make_req(OP_CMD,      8'h00, 8'd0,   8'd0,   8'd0));
        send_request(make_req(OP_CMD,      8'hFF, 8'hFF,  8'hFF,  8'hFF));
        send_request(make_req(OP_CHAR,     8'hA5, 8'd1,   8'd0,   8'd0));
        send_request(make_req(OP_CHAR,     8'h5A, 8'd0,   8'd0,   8'd0));
        send_request(make_req(OP_CURSOR,   8'h00, LINE1,  8'd0,   8'd0));
        send_request(make_req(OP_CURSOR,   8'hFF, LINE2,  8'd255, 8'd0));
        send_request(make_req(OP_CURSOR,   8'h00, 8'd0,   8'd3,   8'd0));
        send_request(make_req(OP_CURSOR,   8'h00, 8'd3,   8'd3,   8'd0));
        send_request(make_req(OP_CHAR_POS, 8'hFF, LINE2,  8'd15,  8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h00, LINE1,  8'd0,   8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h41, LINE1,  8'd16,  8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h41, LINE2,  8'd255, 8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h41, 8'd255, 8'd5,   8'd0));
        send_request(make_req(OP_SLOT,     8'h00, 8'd0,   8'd0,   8'd0));
        send_request(make_req(OP_SLOT,     8'h00, 8'd0,   8'd0,   8'd7));
        send_request(make_req(OP_SLOT,     8'h00, 8'd0,   8'd0,   8'd8));
        send_request(make_req(OP_SLOT,     8'h00, 8'd0,   8'd0,   8'd255));
        send_request(make_req(OP_SPARE6,   8'hFF, LINE1,  8'd1,   8'd1));
        send_request(make_req(OP_SPARE7,   8'hFF, LINE2,  8'd1,   8'd1));
    endtask

    task automatic test_timing_extremes();
        wait_drained();
        set_timing(16'h0000, 16'h0000, 16'h0000);
        send_request(make_req(OP_INIT,     8'h00, 8'd0,  8'd0, 8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h41, LINE1, 8'd7, 8'd0));
        wait_drained();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(make_req(OP_INIT,     8'h00, 8'd0,  8'd0, 8'd0));
        send_request(make_req(OP_CHAR_POS, 8'h7E, LINE2, 8'd9, 8'd0));
        wait_drained();
        set_timing(16'h0000, 16'hFFFF, 16'h0001);
        send_request(make_req(OP_INIT,     8'h00, 8'd0,  8'd0, 8'd0));
        send_request(make_req(OP_SLOT,     8'h00, 8'd0,  8'd0, 8'd3));
    endtask

    task automatic test_random_traffic();
        int round;
        int k;
        for (round = 0; round < ROUNDS; round++) begin
            // hold requests until every phase so far has come out
            wait_drained();
            set_timing(random_timing(), random_timing(), random_timing());
            gaps_on = (round != 2);
            for (k = 0; k < ROUND_ITEMS; k++)
                send_request(random_request());
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_timing_extremes();
        test_random_traffic();
        wait_drained();
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_phases.size() == 0)
            $display("char_lcd_nibble_write_sequencer_top: match");
        else
            $display("char_lcd_nibble_write_sequencer_top: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/lcdseq_pkg.sv
sv/lcdseq_ctrl.sv
sv/lcdseq_dp.sv
sv/char_lcd_nibble_write_sequencer_top.sv
sim/tb.sv
